[hw/rtl/pts_pkg.sv]
`default_nettype none

package pts_pkg;

  localparam int unsigned TaskSlots = 16;
  localparam int unsigned IdxW      = $clog2(TaskSlots);
  localparam int unsigned CntW      = $clog2(TaskSlots + 1);

  localparam logic [7:0] IdlePriority = 8'd100;
  localparam logic [7:0] PickLimit    = 8'd101;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELAY  = 3'd1,
    OP_TICK   = 3'd2,
    OP_ENTER  = 3'd3,
    OP_EXIT   = 3'd4,
    OP_START  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NO_READY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            clear;
    logic            valid;
    logic [IdxW-1:0] idx;
  } pick_ctl_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } pick_res_t;

endpackage

`default_nettype wire

[hw/rtl/priority_task_scheduler.sv]
// priority task scheduler
// input channel: one beat per operation (op_i, priority_req_i, delay_ticks_i),
// taken when in_valid_i is high and in_stall_o is low
// output channel: exactly one result beat per operation, held in an output
// register until out_valid_o is high and out_stall_i is low
// the slot table lives in two registered-read rams (priority, delay); the
// number of used slots n is a fill count, as slots fill from slot 0 up
// sequence: create, delay, tick, start and the exit that leaves the outermost
// interrupt walk the n used slots through the ram read port; such an item
// passes accept, exec, walk and finish; enter, the other exits, a create
// into a full table and unknown ops skip the walk (accept, exec, finish)
// one item is in flight at a time; a new beat is taken while the previous
// result still waits in the output register
// reset: a table init state (slot 0 = idle task, priority 100) with
// in_stall_o high, then the block accepts beats
// a stalled result holds; the finishing step waits until the output
// register is free, and the input stays stalled meanwhile
`default_nettype none

module priority_task_scheduler
  import pts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [15:0] delay_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       task_index_o,
  output logic             switched_o,
  output logic             first_dispatch_o,
  output logic [15:0]      switch_count_o,
  output logic [15:0]      tick_count_o,
  output logic [7:0]       isr_depth_o,
  output logic [1:0]       status_o
);

  // sequencer and architectural state
  state_e          state_q, state_d;
  logic [CntW-1:0] used_cnt_q, used_cnt_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic            running_q, running_d;
  logic            await_q, await_d;
  logic [7:0]      depth_q, depth_d;
  logic [15:0]     switch_q, switch_d;
  logic [15:0]     tick_q, tick_d;
  status_e         status_q, status_d;
  logic            walk_tick_q, walk_tick_d;
  logic            pick_run_q, pick_run_d;

  // walk read pipeline
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  // captured item
  logic [2:0]      op_q;
  logic [7:0]      prio_q;
  logic [15:0]     dly_q;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [3:0]      out_task_q;
  logic            out_sw_q;
  logic            out_first_q;
  logic [15:0]     out_switch_q;
  logic [15:0]     out_tick_q;
  logic [7:0]      out_depth_q;
  status_e         out_status_q;

  // ram ports
  logic            prio_we;
  logic [IdxW-1:0] prio_waddr;
  logic [7:0]      prio_wdata;
  logic            dly_we;
  logic [IdxW-1:0] dly_waddr;
  logic [15:0]     dly_wdata;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      prio_rdata;
  logic [15:0]     dly_rdata;

  pick_ctl_t       pick_ctl;
  pick_res_t       pick_res;

  logic            in_accept;
  logic            load_out;
  logic            sw;
  logic            first;
  logic [IdxW+3:0] cur_ext;

  pts_ram #(
    .Width(8)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (prio_we),
    .waddr_i(prio_waddr),
    .wdata_i(prio_wdata),
    .raddr_i(rd_addr),
    .rdata_o(prio_rdata)
  );

  pts_ram #(
    .Width(16)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(dly_wdata),
    .raddr_i(rd_addr),
    .rdata_o(dly_rdata)
  );

  pts_pick u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pick_ctl),
    .prio_i (prio_rdata),
    .delay_i(dly_rdata),
    .res_o  (pick_res)
  );

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    used_cnt_d  = used_cnt_q;
    cur_d       = cur_q;
    running_d   = running_q;
    await_d     = await_q;
    depth_d     = depth_q;
    switch_d    = switch_q;
    tick_d      = tick_q;
    status_d    = status_q;
    walk_tick_d = walk_tick_q;
    pick_run_d  = pick_run_q;
    rd_cnt_d    = rd_cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_cnt_q[IdxW-1:0];
    rd_addr     = rd_cnt_q[IdxW-1:0];

    prio_we     = 1'b0;
    prio_waddr  = used_cnt_q[IdxW-1:0];
    prio_wdata  = prio_q;
    dly_we      = 1'b0;
    dly_waddr   = used_cnt_q[IdxW-1:0];
    dly_wdata   = '0;

    pick_ctl.clear = 1'b0;
    pick_ctl.valid = rd_vld_q && !walk_tick_q;
    pick_ctl.idx   = rd_idx_q;

    in_stall_o = 1'b1;
    load_out   = 1'b0;
    sw         = 1'b0;
    first      = 1'b0;

    unique case (state_q)
      S_INIT: begin
        // idle task in slot 0
        prio_we    = 1'b1;
        prio_waddr = '0;
        prio_wdata = IdlePriority;
        dly_we     = 1'b1;
        dly_waddr  = '0;
        state_d    = S_IDLE;
      end

      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          status_d    = ST_OK;
          pick_run_d  = 1'b0;
          walk_tick_d = 1'b0;
          state_d     = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_cnt_d       = '0;
        pick_ctl.clear = 1'b1;
        state_d        = S_DONE;
        unique case (op_q)
          OP_CREATE: begin
            if (used_cnt_q == CntW'(TaskSlots)) begin
              status_d = ST_FULL;
            end else begin
              // new slot at the fill count, delay cleared
              prio_we    = 1'b1;
              dly_we     = 1'b1;
              used_cnt_d = used_cnt_q + 1'b1;
              pick_run_d = 1'b1;
              state_d    = S_WALK;
            end
          end
          OP_DELAY: begin
            dly_we     = 1'b1;
            dly_waddr  = cur_q;
            dly_wdata  = dly_q;
            pick_run_d = 1'b1;
            state_d    = S_WALK;
          end
          OP_TICK: begin
            tick_d      = tick_q + 16'd1;
            walk_tick_d = 1'b1;
            state_d     = S_WALK;
          end
          OP_ENTER: begin
            if (depth_q != 8'hFF) begin
              depth_d = depth_q + 8'd1;
            end
          end
          OP_EXIT: begin
            if (depth_q == 8'd0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              depth_d = depth_q - 8'd1;
              if (depth_q == 8'd1) begin
                pick_run_d = 1'b1;
                state_d    = S_WALK;
              end
            end
          end
          OP_START: begin
            running_d  = 1'b1;
            pick_run_d = 1'b1;
            state_d    = S_WALK;
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        // issue one read a cycle, consume its data in the next cycle
        if (rd_cnt_q < used_cnt_q) begin
          rd_vld_d = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // tick writes back behind the read pointer, never the same entry
        if (rd_vld_q && walk_tick_q && (dly_rdata != 16'd0)) begin
          dly_we    = 1'b1;
          dly_waddr = rd_idx_q;
          dly_wdata = dly_rdata - 16'd1;
        end
        if ((rd_cnt_q == used_cnt_q) && !rd_vld_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          if (pick_run_q) begin
            if (!pick_res.found) begin
              status_d = ST_NO_READY;
            end else if (!running_q) begin
              cur_d = pick_res.idx;
            end else if ((pick_res.idx != cur_q) || await_q) begin
              sw       = 1'b1;
              first    = await_q;
              await_d  = 1'b0;
              switch_d = switch_q + 16'd1;
              cur_d    = pick_res.idx;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign cur_ext     = {4'b0000, cur_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      used_cnt_q  <= CntW'(1);
      cur_q       <= '0;
      running_q   <= 1'b0;
      await_q     <= 1'b1;
      depth_q     <= '0;
      switch_q    <= '0;
      tick_q      <= '0;
      status_q    <= ST_OK;
      walk_tick_q <= 1'b0;
      pick_run_q  <= 1'b0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_cnt_q  <= used_cnt_d;
      cur_q       <= cur_d;
      running_q   <= running_d;
      await_q     <= await_d;
      depth_q     <= depth_d;
      switch_q    <= switch_d;
      tick_q      <= tick_d;
      status_q    <= status_d;
      walk_tick_q <= walk_tick_d;
      pick_run_q  <= pick_run_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (in_accept) begin
      op_q   <= op_i;
      prio_q <= priority_req_i;
      dly_q  <= delay_ticks_i;
    end
    if (load_out) begin
      out_task_q   <= cur_ext[3:0];
      out_sw_q     <= sw;
      out_first_q  <= first;
      out_switch_q <= switch_d;
      out_tick_q   <= tick_q;
      out_depth_q  <= depth_q;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign task_index_o     = out_task_q;
  assign switched_o       = out_sw_q;
  assign first_dispatch_o = out_first_q;
  assign switch_count_o   = out_switch_q;
  assign tick_count_o     = out_tick_q;
  assign isr_depth_o      = out_depth_q;
  assign status_o         = out_status_q;

  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_cnt_q != '0) && (used_cnt_q <= CntW'(TaskSlots)))
    else $error("fill count out of range");

  a_current_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(cur_q) < used_cnt_q)
    else $error("current task points past the used slots");

  a_first_is_switch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && first |=> (out_sw_q && running_q && !await_q))
    else $error("first dispatch without a switch");

endmodule

`default_nettype wire

[hw/rtl/pts_ram.sv]
`default_nettype none

module pts_ram
  import pts_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [TaskSlots];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/pts_pick.sv]
`default_nettype none

module pts_pick
  import pts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pick_ctl_t   ctl_i,
  input  wire logic [7:0]  prio_i,
  input  wire logic [15:0] delay_i,
  output pick_res_t        res_o
);

  logic [7:0]      best_q, best_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // later slot wins ties, hence <=
  always_comb begin
    best_d  = best_q;
    found_d = found_q;
    idx_d   = idx_q;
    if (ctl_i.clear) begin
      best_d  = PickLimit;
      found_d = 1'b0;
      idx_d   = '0;
    end else if (ctl_i.valid && (delay_i == 16'd0) && (prio_i <= best_q)) begin
      best_d  = prio_i;
      found_d = 1'b1;
      idx_d   = ctl_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= PickLimit;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      best_q  <= best_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  assign res_o.found = found_q;
  assign res_o.idx   = idx_q;

  a_best_in_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_q <= PickLimit))
    else $error("pick holds a priority above the limit");

  a_clear_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (!found_q && (best_q == PickLimit)))
    else $error("pick not cleared");

endmodule

`default_nettype wire

[tb/sv/priority_task_scheduler_test.sv]
`default_nettype none

module priority_task_scheduler_test;
  import pts_pkg::*;

  // op codes the block ignores
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // cycles with no beat on either channel before the run is called hung
  localparam int QuietLimit = 4000;
  // drain time after the last result, longer than the slowest item
  localparam int DrainCycles = 40;

  // one result beat, packed in port order
  typedef struct packed {
    logic [3:0]  task_index;
    logic        switched;
    logic        first_dispatch;
    logic [15:0] switch_count;
    logic [15:0] tick_count;
    logic [7:0]  isr_depth;
    logic [1:0]  status;
  } sched_result_t;

  // mirror of the task table and kernel state, plus the results still owed
  class scheduler_mirror;
    logic            used [TaskSlots];
    logic [7:0]      prio [TaskSlots];
    logic [15:0]     wait_ticks [TaskSlots];
    logic [IdxW-1:0] current;
    logic            running;
    logic            awaiting_first;
    logic [7:0]      depth;
    logic [15:0]     switch_total;
    logic [15:0]     tick_total;
    sched_result_t   due_results[$];
    int              mismatches;

    function new();
      for (int i = 0; i < TaskSlots; i++) begin
        used[i]       = 1'b0;
        prio[i]       = 8'd0;
        wait_ticks[i] = 16'd0;
      end
      // idle task sits in slot 0 from reset
      used[0]        = 1'b1;
      prio[0]        = IdlePriority;
      current        = '0;
      running        = 1'b0;
      awaiting_first = 1'b1;
      depth          = 8'd0;
      switch_total   = 16'd0;
      tick_total     = 16'd0;
      mismatches     = 0;
    endfunction

    // walk the used slots, best ready priority wins, later slot wins ties;
    // returns 0 when nothing is ready
    function bit pick_task(output bit sw, output bit first);
      int unsigned best;
      int unsigned pick;
      bit          found;
      best  = PickLimit;
      pick  = 0;
      found = 1'b0;
      sw    = 1'b0;
      first = 1'b0;
      for (int i = 0; i < TaskSlots; i++) begin
        if (!used[i]) break;
        if (wait_ticks[i] != 16'd0) continue;
        if (prio[i] <= best) begin
          best  = prio[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) return 1'b0;
      if (!running) begin
        current = IdxW'(pick);
        return 1'b1;
      end
      if (pick == current && !awaiting_first) return 1'b1;
      first          = awaiting_first;
      awaiting_first = 1'b0;
      switch_total++;
      current        = IdxW'(pick);
      sw             = 1'b1;
      return 1'b1;
    endfunction

    // accepted input beat: update the mirror and queue the result it owes
    function void take_op(logic [2:0] op, logic [7:0] p, logic [15:0] d);
      sched_result_t want;
      status_e       st;
      bit            sw;
      bit            first;
      int            slot;
      st    = ST_OK;
      sw    = 1'b0;
      first = 1'b0;
      case (op)
        OP_CREATE: begin
          slot = 0;
          while (slot < TaskSlots && used[slot]) slot++;
          if (slot == TaskSlots) begin
            st = ST_FULL;
          end else begin
            used[slot]       = 1'b1;
            prio[slot]       = p;
            wait_ticks[slot] = 16'd0;
            if (!pick_task(sw, first)) st = ST_NO_READY;
          end
        end
        OP_DELAY: begin
          wait_ticks[current] = d;
          if (!pick_task(sw, first)) st = ST_NO_READY;
        end
        OP_TICK: begin
          tick_total++;
          for (int i = 0; i < TaskSlots; i++) begin
            if (!used[i]) break;
            if (wait_ticks[i] != 16'd0) wait_ticks[i]--;
          end
        end
        OP_ENTER: begin
          if (depth != 8'hFF) depth++;
        end
        OP_EXIT: begin
          if (depth == 8'd0) begin
            st = ST_UNDERFLOW;
          end else begin
            depth--;
            if (depth == 8'd0) begin
              if (!pick_task(sw, first)) st = ST_NO_READY;
            end
          end
        end
        OP_START: begin
          running = 1'b1;
          if (!pick_task(sw, first)) st = ST_NO_READY;
        end
        default: ;
      endcase
      want.task_index     = current;
      want.switched       = sw;
      want.first_dispatch = first;
      want.switch_count   = switch_total;
      want.tick_count     = tick_total;
      want.isr_depth      = depth;
      want.status         = st;
      due_results.push_back(want);
    endfunction

    // accepted result beat: compare against the oldest owed result
    function void match_result(sched_result_t got);
      sched_result_t want;
      bit            bad;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: idx %0d sw %0d first %0d sw_cnt %0d tick %0d depth %0d st %0d",
                   got.task_index, got.switched, got.first_dispatch, got.switch_count,
                   got.tick_count, got.isr_depth, got.status);
        return;
      end
      want = due_results.pop_front();
      bad = (got.task_index !== want.task_index) ||
            (got.switched !== want.switched) ||
            (got.first_dispatch !== want.first_dispatch) ||
            (got.switch_count !== want.switch_count) ||
            (got.tick_count !== want.tick_count) ||
            (got.isr_depth !== want.isr_depth) ||
            (got.status !== want.status);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: want idx %0d sw %0d first %0d sw_cnt %0d tick %0d depth %0d st %0d",
                   want.task_index, want.switched, want.first_dispatch, want.switch_count,
                   want.tick_count, want.isr_depth, want.status);
          $display("                 got  idx %0d sw %0d first %0d sw_cnt %0d tick %0d depth %0d st %0d",
                   got.task_index, got.switched, got.first_dispatch, got.switch_count,
                   got.tick_count, got.isr_depth, got.status);
        end
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [2:0]  op_i           = OP_TICK;
  logic [7:0]  priority_req_i = 8'd0;
  logic [15:0] delay_ticks_i  = 16'd0;
  logic        out_stall_i    = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [3:0]  task_index_o;
  logic        switched_o;
  logic        first_dispatch_o;
  logic [15:0] switch_count_o;
  logic [15:0] tick_count_o;
  logic [7:0]  isr_depth_o;
  logic [1:0]  status_o;

  // idling odds in percent, changed per phase
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  scheduler_mirror board = new();

  priority_task_scheduler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .priority_req_i   (priority_req_i),
    .delay_ticks_i    (delay_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .task_index_o     (task_index_o),
    .switched_o       (switched_o),
    .first_dispatch_o (first_dispatch_o),
    .switch_count_o   (switch_count_o),
    .tick_count_o     (tick_count_o),
    .isr_depth_o      (isr_depth_o),
    .status_o         (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  // both channels sampled at the rising edge; the result side goes first so
  // a beat that lands with an empty queue is flagged as unexpected
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.match_result({task_index_o, switched_o, first_dispatch_o, switch_count_o,
                            tick_count_o, isr_depth_o, status_o});
      if (in_valid_i && !in_stall_o)
        board.take_op(op_i, priority_req_i, delay_ticks_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // hang detector
  initial begin
    while (quiet_cycles < QuietLimit) @(negedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // one input beat: optional idle gap, then hold the payload until taken;
  // called and returns at a falling edge
  task automatic push_op(input logic [2:0] op, input logic [7:0] p, input logic [15:0] d);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    op_i           = op;
    priority_req_i = p;
    delay_ticks_i  = d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random op mix: ticks and delays dominate so tasks keep blocking and
  // waking; creates are rare so the table fills part way through the run
  task automatic run_random(input int count);
    int          r;
    logic [2:0]  op;
    logic [7:0]  p;
    logic [15:0] d;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8)       op = OP_CREATE;
      else if (r < 28) op = OP_DELAY;
      else if (r < 56) op = OP_TICK;
      else if (r < 70) op = OP_ENTER;
      else if (r < 84) op = OP_EXIT;
      else if (r < 92) op = OP_START;
      else if (r < 96) op = OpSpareLo;
      else             op = OpSpareHi;
      // priorities: edges of the pick window now and then, else anything
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 4))
          0:       p = 8'd0;
          1:       p = IdlePriority;
          2:       p = PickLimit;
          3:       p = PickLimit + 8'd1;
          default: p = 8'hFF;
        endcase
      end else begin
        p = 8'($urandom_range(0, 255));
      end
      // delays: mostly short so they expire, a few that block for good
      r = $urandom_range(0, 99);
      if (r < 60)      d = 16'($urandom_range(0, 4));
      else if (r < 94) d = 16'($urandom_range(0, 40));
      else             d = 16'($urandom_range(0, 65535));
      push_op(op, p, d);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: special cases in a known order, no idling
    push_op(OP_EXIT, 8'd0, 16'd0);          // exit with no interrupt open
    push_op(OP_DELAY, 8'hFF, 16'd2);        // idle task blocked, nothing ready
    push_op(OP_START, 8'd0, 16'd0);         // start with nothing ready
    push_op(OP_TICK, 8'd0, 16'd0);
    push_op(OP_TICK, 8'd0, 16'd0);          // idle task ready again
    push_op(OP_START, 8'd0, 16'd0);         // first dispatch onto same task
    push_op(OP_CREATE, 8'hFF, 16'hFFFF);    // above the pick limit, never chosen
    push_op(OP_CREATE, PickLimit, 16'd0);   // right at the limit
    push_op(OP_CREATE, PickLimit, 16'd0);   // tie at the limit, both lose to the idle task
    push_op(OP_CREATE, PickLimit + 8'd1, 16'd0);
    push_op(OP_ENTER, 8'd0, 16'd0);
    push_op(OP_ENTER, 8'd0, 16'd0);
    push_op(OP_CREATE, 8'd0, 16'd0);        // most urgent, created inside isr
    push_op(OP_EXIT, 8'd0, 16'd0);          // still nested, no pick
    push_op(OP_EXIT, 8'd0, 16'd0);          // outermost exit reschedules
    push_op(OP_DELAY, 8'd0, 16'hFFFF);      // urgent task blocked for good
    push_op(OP_START, 8'd0, 16'd0);         // repeated start
    push_op(OpSpareLo, 8'hFF, 16'hFFFF);
    push_op(OpSpareHi, 8'hFF, 16'hFFFF);
    push_op(OP_DELAY, 8'hFF, 16'd0);        // zero delay, nothing moves
    push_op(OP_DELAY, 8'h55, 16'hAAAA);
    push_op(OP_DELAY, 8'hAA, 16'h5555);
    push_op(OP_TICK, 8'hFF, 16'hFFFF);

    // random phases with different idling on each side
    run_random(80);
    idle_pct = 78;
    run_random(80);
    idle_pct  = 0;
    stall_pct = 78;
    run_random(80);
    idle_pct  = 21;
    stall_pct = 21;
    run_random(80);

    // interrupt storm: nesting runs into saturation, then a few exits from the top
    for (int k = 0; k < 258; k++)
      push_op(OP_ENTER, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    for (int k = 0; k < 4; k++)
      push_op(OP_EXIT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    in_valid_i = 1'b0;

    // drain, then give a late stray beat a chance to show
    while (board.due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (board.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
